[hdl/lsw_pkg.sv]
// Shared types, constants and register codes for the line segment window clipper.
package lsw_pkg;

	localparam int CW          = 16;          // coordinate width
	localparam int PW          = 2 * CW + 2;  // cross-product width
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 4;
	localparam int INTERP_LAT  = CW + 2;      // multiply, CW divide steps, round
	localparam int QUEUE_DEPTH = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_Y_MIN = 2'd1;
	localparam logic [1:0] REG_X_MAX = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	// edge kinds found by the classifier
	localparam logic [1:0] EK_SKIP  = 2'd0;   // parallel, inside
	localparam logic [1:0] EK_REJ   = 2'd1;   // parallel, outside
	localparam logic [1:0] EK_ENTER = 2'd2;   // p < 0, bounds u1
	localparam logic [1:0] EK_EXIT  = 2'd3;   // p > 0, bounds u2

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] prod_t;

	localparam coord_t WIN_X_MIN_RST = CW'(100);
	localparam coord_t WIN_Y_MIN_RST = CW'(100);
	localparam coord_t WIN_X_MAX_RST = CW'(400);
	localparam coord_t WIN_Y_MAX_RST = CW'(350);

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [CW-1:0] end_x;
		logic signed [CW-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic                 visible;
		logic signed [CW-1:0] clipped_start_x;
		logic signed [CW-1:0] clipped_start_y;
		logic signed [CW-1:0] clipped_end_x;
		logic signed [CW-1:0] clipped_end_y;
	} clip_t;

	typedef struct packed {
		coord_t x_min;
		coord_t y_min;
		coord_t x_max;
		coord_t y_max;
	} win_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [CW:0] tn;   // candidate numerator
		logic [CW-1:0]      td;   // candidate denominator, > 0 when used
	} edge_t;

	// queue entry: one classified item
	typedef struct packed {
		coord_t             x0;
		coord_t             y0;
		logic signed [CW:0] dx;
		logic signed [CW:0] dy;
		edge_t [3:0]        edges;  // edges[0] is processed next
	} work_t;

	// item state while it walks the edge stages
	typedef struct packed {
		coord_t             x0;
		coord_t             y0;
		logic signed [CW:0] dx;
		logic signed [CW:0] dy;
		edge_t [3:0]        edges;
		logic [CW-1:0]      n1;
		logic [CW-1:0]      d1;
		logic [CW-1:0]      n2;
		logic [CW-1:0]      d2;
		logic               rej;
	} trk_t;

endpackage

[hdl/lsw_front.sv]
// Front end: forms p and q for the four window edges and classifies each edge.
module lsw_front (
	input  lsw_pkg::seg_t  seg,
	input  lsw_pkg::win_t  win,
	output lsw_pkg::work_t work
);
	import lsw_pkg::*;

	function automatic edge_t classify(input logic signed [CW:0] p, input logic signed [CW:0] q);
		edge_t e;
		logic signed [CW:0] np;
		np = -p;
		e.kind = EK_SKIP;
		e.tn   = q;
		e.td   = p[CW-1:0];
		if (p == '0) begin
			e.kind = q[CW] ? EK_REJ : EK_SKIP;
		end else if (p[CW]) begin
			e.kind = EK_ENTER;
			e.tn   = -q;
			e.td   = np[CW-1:0];
		end else begin
			e.kind = EK_EXIT;
		end
		return e;
	endfunction

	logic signed [CW:0] x0, y0, x1, y1, dx, dy;
	logic signed [CW:0] xmin, ymin, xmax, ymax;

	always_comb begin
		x0   = {seg.start_x[CW-1], seg.start_x};
		y0   = {seg.start_y[CW-1], seg.start_y};
		x1   = {seg.end_x[CW-1], seg.end_x};
		y1   = {seg.end_y[CW-1], seg.end_y};
		xmin = {win.x_min[CW-1], win.x_min};
		ymin = {win.y_min[CW-1], win.y_min};
		xmax = {win.x_max[CW-1], win.x_max};
		ymax = {win.y_max[CW-1], win.y_max};
		dx   = x1 - x0;
		dy   = y1 - y0;
		work.x0       = seg.start_x;
		work.y0       = seg.start_y;
		work.dx       = dx;
		work.dy       = dy;
		// order: left, right, bottom, top
		work.edges[0] = classify(-dx, x0 - xmin);
		work.edges[1] = classify(dx, xmax - x0);
		work.edges[2] = classify(-dy, y0 - ymin);
		work.edges[3] = classify(dy, ymax - y0);
	end

endmodule

[hdl/lsw_queue.sv]
// Short item queue between the classifier and the clipping pipeline.
module lsw_queue #(
	parameter int DEPTH = lsw_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lsw_pkg::work_t din,
	input  logic           pop,
	output lsw_pkg::work_t dout,
	output logic           full,
	output logic           empty
);
	import lsw_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	work_t            mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]   cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lsw_edge.sv]
// One edge step: cross-products in the first stage, reject and narrow in the second.
module lsw_edge (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_vld,
	input  lsw_pkg::trk_t in_trk,
	output logic          out_vld,
	output lsw_pkg::trk_t out_trk
);
	import lsw_pkg::*;

	edge_t e;
	prod_t tn_w, td_w, n1_w, d1_w, n2_w, d2_w;
	logic  vld_s1, vld_s2;
	trk_t  trk_s1, trk_s2, nxt;
	prod_t a1_s1, b1_s1, a2_s1, b2_s1;

	always_comb begin
		e    = in_trk.edges[0];
		tn_w = prod_t'(e.tn);
		td_w = prod_t'({1'b0, e.td});
		n1_w = prod_t'({1'b0, in_trk.n1});
		d1_w = prod_t'({1'b0, in_trk.d1});
		n2_w = prod_t'({1'b0, in_trk.n2});
		d2_w = prod_t'({1'b0, in_trk.d2});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s1 <= in_trk;
			a1_s1  <= tn_w * d1_w;   // tn/td vs n1/d1
			b1_s1  <= n1_w * td_w;
			a2_s1  <= tn_w * d2_w;   // tn/td vs n2/d2
			b2_s1  <= n2_w * td_w;
		end
	end

	always_comb begin
		nxt       = trk_s1;
		nxt.edges = {edge_t'('0), trk_s1.edges[3:1]};
		unique case (trk_s1.edges[0].kind)
			EK_SKIP: begin
			end
			EK_REJ: begin
				nxt.rej = 1'b1;
			end
			EK_ENTER: begin
				if (a2_s1 > b2_s1) begin
					nxt.rej = 1'b1;
				end
				if (a1_s1 > b1_s1) begin
					nxt.n1 = trk_s1.edges[0].tn[CW-1:0];
					nxt.d1 = trk_s1.edges[0].td;
				end
			end
			EK_EXIT: begin
				if (a1_s1 < b1_s1) begin
					nxt.rej = 1'b1;
				end
				if (a2_s1 < b2_s1) begin
					nxt.n2 = trk_s1.edges[0].tn[CW-1:0];
					nxt.d2 = trk_s1.edges[0].td;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s2 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign out_vld = vld_s2;
	assign out_trk = trk_s2;

endmodule

[hdl/lsw_interp.sv]
// Endpoint interpolation: base + n*delta/d, restoring divide one bit a stage, round half away.
module lsw_interp (
	input  logic                         clk,
	input  logic                         adv,
	input  lsw_pkg::coord_t              base,
	input  logic signed [lsw_pkg::CW:0]  delta,
	input  logic [lsw_pkg::CW-1:0]       n,
	input  logic [lsw_pkg::CW-1:0]       d,
	output lsw_pkg::coord_t              res
);
	import lsw_pkg::*;

	typedef struct packed {
		logic [2*CW-1:0] num;
		logic [CW-1:0]   d;
		coord_t          base;
		logic            neg;
	} mul_t;

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [CW-1:0] lo;
		logic [CW-1:0] quo;
		logic [CW-1:0] d;
		coord_t        base;
		logic          neg;
	} div_t;

	function automatic div_t div_step(input div_t x);
		logic [CW:0] t;
		logic        ge;
		div_t        y;
		t     = {x.rem, x.lo[CW-1]};
		ge    = (t >= {1'b0, x.d});
		y     = x;
		y.rem = ge ? CW'(t - {1'b0, x.d}) : t[CW-1:0];
		y.lo  = {x.lo[CW-2:0], 1'b0};
		y.quo = {x.quo[CW-2:0], ge};
		return y;
	endfunction

	function automatic coord_t round_out(input div_t x);
		logic signed [CW+1:0] qv, v, v2;
		logic [CW-1:0]        r;
		logic [CW:0]          r2;
		logic                 up;
		if (!x.neg) begin
			qv = {2'b00, x.quo};
			r  = x.rem;
		end else if (x.rem == '0) begin
			qv = -{2'b00, x.quo};
			r  = '0;
		end else begin
			qv = -{2'b00, x.quo} - 1'b1;
			r  = x.d - x.rem;
		end
		v  = {{2{x.base[CW-1]}}, x.base} + qv;
		r2 = {r, 1'b0};
		up = (r2 > {1'b0, x.d}) || ((r2 == {1'b0, x.d}) && !v[CW+1]);
		v2 = v + {{(CW+1){1'b0}}, up};
		return v2[CW-1:0];
	endfunction

	logic [CW:0] mag_w;
	mul_t        mul_s1;
	div_t        div_in [CW];
	div_t        div_s  [CW];
	coord_t      res_s;

	assign mag_w = delta[CW] ? -delta : delta;

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1.num  <= {{CW{1'b0}}, n} * {{CW{1'b0}}, mag_w[CW-1:0]};
			mul_s1.d    <= d;
			mul_s1.base <= base;
			mul_s1.neg  <= delta[CW];
		end
	end

	// numerator < d * 2^CW, so the upper half starts below d
	always_comb begin
		div_in[0].rem  = mul_s1.num[2*CW-1:CW];
		div_in[0].lo   = mul_s1.num[CW-1:0];
		div_in[0].quo  = '0;
		div_in[0].d    = mul_s1.d;
		div_in[0].base = mul_s1.base;
		div_in[0].neg  = mul_s1.neg;
		for (int k = 1; k < CW; k++) begin
			div_in[k] = div_s[k-1];
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= div_step(div_in[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s <= round_out(div_s[CW-1]);
		end
	end

	assign res = res_s;

endmodule

[hdl/line_segment_window_clipper.sv]
// Throughput: one item per cycle unless clip_stall holds a result; every step is a fixed pipeline stage.
// The back pipeline advances as a whole whenever the output register is free or taken.
// A 4-entry queue lets the input keep accepting while the back end waits.
// Reset (arst_n low, asynchronous): all valid bits and queue pointers clear,
// window registers return to x 100..400, y 100..350.
// Top level: APB window registers, classifier, queue, edge pipeline, interpolators.
module line_segment_window_clipper #(
	parameter int QUEUE_DEPTH = lsw_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// segment input channel
	input  logic                         seg_valid,
	output logic                         seg_stall,
	input  lsw_pkg::seg_t                seg,
	// clipped result channel
	output logic                         clip_valid,
	input  logic                         clip_stall,
	output lsw_pkg::clip_t               clip,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lsw_pkg::ADDR_W-1:0]   paddr,
	input  logic [lsw_pkg::DATA_W-1:0]   pwdata,
	output logic [lsw_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import lsw_pkg::*;

	// ---------------- window registers ----------------
	win_t          win_q;
	coord_t        rd_reg;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.x_min <= WIN_X_MIN_RST;
			win_q.y_min <= WIN_Y_MIN_RST;
			win_q.x_max <= WIN_X_MAX_RST;
			win_q.y_max <= WIN_Y_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_X_MIN: win_q.x_min <= pwdata[CW-1:0];
				REG_Y_MIN: win_q.y_min <= pwdata[CW-1:0];
				REG_X_MAX: win_q.x_max <= pwdata[CW-1:0];
				REG_Y_MAX: win_q.y_max <= pwdata[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_X_MIN: rd_reg = win_q.x_min;
			REG_Y_MIN: rd_reg = win_q.y_min;
			REG_X_MAX: rd_reg = win_q.x_max;
			REG_Y_MAX: rd_reg = win_q.y_max;
			default:   rd_reg = win_q.x_min;
		endcase
	end

	// registers read back sign-extended
	assign prdata = {{(DATA_W-CW){rd_reg[CW-1]}}, rd_reg};

	// ---------------- front: classify and queue ----------------
	work_t work_in, work_out;
	logic  q_full, q_empty, q_pop;
	logic  adv;

	lsw_front u_front (
		.seg  (seg),
		.win  (win_q),
		.work (work_in)
	);

	lsw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (seg_valid),
		.din    (work_in),
		.pop    (q_pop),
		.dout   (work_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	// input stalls only on a full queue
	assign seg_stall = q_full;

	// ---------------- back: edge pipeline ----------------
	// whole back end moves when the output register is empty or being taken
	logic  out_vld_q;
	clip_t clip_q;

	assign adv   = !out_vld_q || !clip_stall;
	assign q_pop = adv && !q_empty;

	logic vld_s0;
	trk_t trk_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= !q_empty;
		end
	end

	// entry stage: u1 = 0/1, u2 = 1/1
	always_ff @(posedge clk) begin
		if (adv) begin
			trk_s0.x0    <= work_out.x0;
			trk_s0.y0    <= work_out.y0;
			trk_s0.dx    <= work_out.dx;
			trk_s0.dy    <= work_out.dy;
			trk_s0.edges <= work_out.edges;
			trk_s0.n1    <= '0;
			trk_s0.d1    <= CW'(1);
			trk_s0.n2    <= CW'(1);
			trk_s0.d2    <= CW'(1);
			trk_s0.rej   <= 1'b0;
		end
	end

	logic edge_vld [5];
	trk_t edge_trk [5];

	assign edge_vld[0] = vld_s0;
	assign edge_trk[0] = trk_s0;

	// left, right, bottom, top in turn; each stage consumes edges[0]
	for (genvar i = 0; i < 4; i++) begin : g_edge
		lsw_edge u_edge (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (edge_vld[i]),
			.in_trk  (edge_trk[i]),
			.out_vld (edge_vld[i+1]),
			.out_trk (edge_trk[i+1])
		);
	end

	// ---------------- interpolation ----------------
	coord_t res [4];

	lsw_interp u_sx (
		.clk (clk), .adv (adv),
		.base (edge_trk[4].x0), .delta (edge_trk[4].dx),
		.n (edge_trk[4].n1), .d (edge_trk[4].d1), .res (res[0])
	);
	lsw_interp u_sy (
		.clk (clk), .adv (adv),
		.base (edge_trk[4].y0), .delta (edge_trk[4].dy),
		.n (edge_trk[4].n1), .d (edge_trk[4].d1), .res (res[1])
	);
	lsw_interp u_ex (
		.clk (clk), .adv (adv),
		.base (edge_trk[4].x0), .delta (edge_trk[4].dx),
		.n (edge_trk[4].n2), .d (edge_trk[4].d2), .res (res[2])
	);
	lsw_interp u_ey (
		.clk (clk), .adv (adv),
		.base (edge_trk[4].y0), .delta (edge_trk[4].dy),
		.n (edge_trk[4].n2), .d (edge_trk[4].d2), .res (res[3])
	);

	// valid and reject flag ride alongside the interpolators
	logic vld_dl_s [INTERP_LAT];
	logic rej_dl_s [INTERP_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < INTERP_LAT; k++) begin
				vld_dl_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_dl_s[0] <= edge_vld[4];
			for (int k = 1; k < INTERP_LAT; k++) begin
				vld_dl_s[k] <= vld_dl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rej_dl_s[0] <= edge_trk[4].rej;
			for (int k = 1; k < INTERP_LAT; k++) begin
				rej_dl_s[k] <= rej_dl_s[k-1];
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_dl_s[INTERP_LAT-1];
		end
	end

	// a rejected item reports zero endpoints
	always_ff @(posedge clk) begin
		if (adv) begin
			clip_q.visible         <= !rej_dl_s[INTERP_LAT-1];
			clip_q.clipped_start_x <= rej_dl_s[INTERP_LAT-1] ? '0 : res[0];
			clip_q.clipped_start_y <= rej_dl_s[INTERP_LAT-1] ? '0 : res[1];
			clip_q.clipped_end_x   <= rej_dl_s[INTERP_LAT-1] ? '0 : res[2];
			clip_q.clipped_end_y   <= rej_dl_s[INTERP_LAT-1] ? '0 : res[3];
		end
	end

	assign clip_valid = out_vld_q;
	assign clip       = clip_q;

endmodule

[hdl/lsw_checker.sv]
// Port-level checks for the line segment window clipper, bound to the top level.
module lsw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         clip_valid,
	input logic                         clip_stall,
	input lsw_pkg::clip_t               clip,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [lsw_pkg::ADDR_W-1:0]   paddr,
	input logic [lsw_pkg::DATA_W-1:0]   pwdata,
	input logic [lsw_pkg::DATA_W-1:0]   prdata,
	input logic                         pready
);
	import lsw_pkg::*;

	// stalled result holds
	a_clip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && clip_stall |=> clip_valid && $stable(clip))
		else $error("clip item changed under stall");

	// rejected items carry zero endpoints
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && !clip.visible |->
			clip.clipped_start_x == '0 && clip.clipped_start_y == '0 &&
			clip.clipped_end_x == '0 && clip.clipped_end_y == '0)
		else $error("rejected item with nonzero endpoints");

	// a written window register reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite && pready) &&
		paddr[3:2] == $past(paddr[3:2]) |->
			prdata[CW-1:0] == $past(pwdata[CW-1:0]))
		else $error("window register readback mismatch");

endmodule

bind line_segment_window_clipper lsw_checker u_lsw_checker (.*);

[tb/line_segment_window_clipper_test.sv]
// Testbench for the line segment window clipper: directed table, then random segments.
`timescale 1ns / 1ps

module line_segment_window_clipper_test;
	import lsw_pkg::*;

	localparam int LATENCY = CW + 12;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	seg_t seg = '0;
	logic clip_valid;
	logic clip_stall = 1'b0;
	clip_t clip;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	always #2 clk = ~clk;

	line_segment_window_clipper dut (
		.clk, .arst_n, .seg_valid, .seg_stall, .seg, .clip_valid, .clip_stall, .clip,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// window copy used by the predictor
	win_t win;
	clip_t expected_clips[$];
	int errors = 0;
	int cycles = 0;
	int segs_sent = 0, clips_seen = 0, visible_seen = 0;
	int send_idle = 0, recv_idle = 0;   // percent idle

	// table row: segment and, where obvious, the clip itself
	typedef struct {
		seg_t  s;
		bit    has_exp;
		clip_t e;
	} row_t;

	// sign of an/ad - bn/bd, denominators positive
	function automatic int frac_cmp(longint an, longint ad, longint bn, longint bd);
		longint l, r;
		l = an * bd;
		r = bn * ad;
		return (l > r) ? 1 : (l < r) ? -1 : 0;
	endfunction

	// base + n*delta/d, rounded half away from zero; floor division
	function automatic coord_t lerp_round(longint base, longint delta, longint n, longint d);
		longint num, q, r, v;
		num = n * delta;
		q = num / d;
		r = num % d;
		if (r < 0) begin
			q = q - 1;
			r = r + d;
		end
		v = base + q;
		if (2 * r > d || (2 * r == d && v >= 0))
			v++;
		return coord_t'(v);
	endfunction

	function automatic clip_t clip_segment(seg_t s);
		longint x0, y0, dx, dy, p[4], q[4], n1, d1, n2, d2, tn, td;
		clip_t c;
		x0 = s.start_x;
		y0 = s.start_y;
		dx = longint'(s.end_x) - x0;
		dy = longint'(s.end_y) - y0;
		p[0] = -dx; q[0] = x0 - win.x_min;
		p[1] = dx;  q[1] = longint'(win.x_max) - x0;
		p[2] = -dy; q[2] = y0 - win.y_min;
		p[3] = dy;  q[3] = longint'(win.y_max) - y0;
		n1 = 0; d1 = 1; n2 = 1; d2 = 1;
		c = '0;
		for (int i = 0; i < 4; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0) return c;
			end else if (p[i] < 0) begin
				tn = -q[i];
				td = -p[i];
				if (frac_cmp(tn, td, n2, d2) > 0) return c;
				if (frac_cmp(tn, td, n1, d1) > 0) begin
					n1 = tn;
					d1 = td;
				end
			end else begin
				tn = q[i];
				td = p[i];
				if (frac_cmp(tn, td, n1, d1) < 0) return c;
				if (frac_cmp(tn, td, n2, d2) < 0) begin
					n2 = tn;
					d2 = td;
				end
			end
		end
		c.visible = 1'b1;
		c.clipped_start_x = lerp_round(x0, dx, n1, d1);
		c.clipped_start_y = lerp_round(y0, dy, n1, d1);
		c.clipped_end_x = lerp_round(x0, dx, n2, d2);
		c.clipped_end_y = lerp_round(y0, dy, n2, d2);
		return c;
	endfunction

	task automatic write_window(logic [1:0] idx, coord_t v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_X_MIN: win.x_min = v;
			REG_Y_MIN: win.y_min = v;
			REG_X_MAX: win.x_max = v;
			default:   win.y_max = v;
		endcase
	endtask

	task automatic set_window(coord_t xl, coord_t yl, coord_t xh, coord_t yh);
		write_window(REG_X_MIN, xl);
		write_window(REG_Y_MIN, yl);
		write_window(REG_X_MAX, xh);
		write_window(REG_Y_MAX, yh);
	endtask

	// hand one segment over; valid stays up into the next item unless the sender idles
	task automatic send_segment(seg_t s, bit has_exp, clip_t e);
		while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		seg <= s;
		do @(posedge clk); while (seg_stall);
		if (has_exp && e != clip_segment(s)) begin
			$display("%0t table row disagrees with predictor: row %h pred %h",
				$time, e, clip_segment(s));
			errors++;
		end
		expected_clips.push_back(has_exp ? e : clip_segment(s));
		segs_sent++;
	endtask

	// wait out every result plus pipeline drain, so the window may change
	task automatic drain();
		seg_valid <= 1'b0;
		while (expected_clips.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic coord_t rnd_coord();
		case ($urandom_range(3, 0))
			0: return coord_t'($urandom());
			1: return coord_t'(int'($urandom_range(500, 0)) - 50);
			2: return $urandom_range(1, 0) ? coord_t'(16'h7fff) : coord_t'(16'h8000);
			default: return coord_t'(int'($urandom_range(60, 0)) + 80);
		endcase
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		clip_t e;
		if (arst_n) begin
			if (clip_valid && !clip_stall) begin
				clips_seen++;
				if (clip.visible) visible_seen++;
				if (expected_clips.size() == 0) begin
					$display("%0t unexpected clip %h", $time, clip);
					errors++;
				end else begin
					e = expected_clips.pop_front();
					if (clip.visible !== e.visible
						|| clip.clipped_start_x !== e.clipped_start_x
						|| clip.clipped_start_y !== e.clipped_start_y
						|| clip.clipped_end_x !== e.clipped_end_x
						|| clip.clipped_end_y !== e.clipped_end_y) begin
						$display("%0t clip mismatch: expected %h actual %h", $time, e, clip);
						errors++;
					end
				end
			end
			clip_stall <= (recv_idle > 0) && ($urandom_range(99, 0) < recv_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		seg_t s;
		win.x_min = WIN_X_MIN_RST;
		win.y_min = WIN_Y_MIN_RST;
		win.x_max = WIN_X_MAX_RST;
		win.y_max = WIN_Y_MAX_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows against the reset window x 100..400, y 100..350
		// fully inside: passes through
		r.s = '{150, 150, 300, 300}; r.has_exp = 1; r.e = '{1, 150, 150, 300, 300};
		rows.push_back(r);
		// horizontal through both side edges
		r.s = '{0, 200, 500, 200}; r.e = '{1, 100, 200, 400, 200}; rows.push_back(r);
		// reversed direction
		r.s = '{500, 200, 0, 200}; r.e = '{1, 400, 200, 100, 200}; rows.push_back(r);
		// vertical through bottom and top
		r.s = '{250, 0, 250, 500}; r.e = '{1, 250, 100, 250, 350}; rows.push_back(r);
		// parallel and outside on the left: rejected
		r.s = '{50, 0, 50, 500}; r.e = '0; rows.push_back(r);
		// parallel outside above
		r.s = '{0, 400, 500, 400}; r.e = '0; rows.push_back(r);
		// single point inside, on corner, outside
		r.s = '{200, 200, 200, 200}; r.e = '{1, 200, 200, 200, 200}; rows.push_back(r);
		r.s = '{100, 100, 100, 100}; r.e = '{1, 100, 100, 100, 100}; rows.push_back(r);
		r.s = '{401, 200, 401, 200}; r.e = '0; rows.push_back(r);
		// along an edge
		r.s = '{100, 0, 100, 500}; r.e = '{1, 100, 100, 100, 350}; rows.push_back(r);
		// coordinate extremes: full-range diagonal and corners
		r.s = '{-32768, -32768, 32767, 32767}; r.has_exp = 0; rows.push_back(r);
		r.s = '{32767, -32768, -32768, 32767}; rows.push_back(r);
		r.s = '{-32768, 32767, 32767, -32768}; rows.push_back(r);
		r.s = '{32767, 32767, 32767, 32767}; r.has_exp = 1; r.e = '0; rows.push_back(r);
		r.s = '{-32768, -32768, -32768, -32768}; r.e = '0; rows.push_back(r);
		// diagonal crossing a corner, rounding cases
		r.s = '{0, 0, 501, 503}; r.has_exp = 0; rows.push_back(r);
		r.s = '{99, 351, 401, 99}; rows.push_back(r);
		r.s = '{-7, 101, 403, 104}; rows.push_back(r);
		r.s = '{399, 0, 402, 1000}; rows.push_back(r);
		// misses the window near a corner
		r.s = '{0, 300, 150, 500}; rows.push_back(r);
		foreach (rows[i]) send_segment(rows[i].s, rows[i].has_exp, rows[i].e);
		drain();

		// inverted window, then extreme windows, then random phases
		set_window(400, 350, 100, 100);
		for (int i = 0; i < 20; i++) begin
			s = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
			send_segment(s, 0, '0);
		end
		s = '{200, 200, 200, 200}; send_segment(s, 1, '0);
		drain();
		set_window(-32768, -32768, 32767, 32767);
		for (int i = 0; i < 20; i++) begin
			s = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
			send_segment(s, 0, '0);
		end
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 8 : (ph == 1) ? 64 : 0;
			recv_idle = (ph == 0) ? 64 : (ph == 1) ? 8 : 0;
			for (int w = 0; w < 3; w++) begin
				if (ph == 2 && w == 2)
					set_window(32767, 32767, 32767, 32767);
				else
					set_window(coord_t'(int'($urandom_range(300, 0)) - 150),
						coord_t'(int'($urandom_range(300, 0)) - 150),
						coord_t'(int'($urandom_range(300, 0)) + 150),
						coord_t'(int'($urandom_range(300, 0)) + 150));
				for (int i = 0; i < 50; i++) begin
					s = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
					send_segment(s, 0, '0);
				end
				drain();
			end
		end
		recv_idle = 0;

		$display("Sent %0d segments over inverted, full-range and random windows;", segs_sent);
		$display("received %0d clips, %0d of them visible.", clips_seen, visible_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
